// ----- design/idiv_pkg.sv -----
package idiv_pkg;

    localparam int W = 64;

    localparam logic OP_UNSIGNED = 1'b0;
    localparam logic OP_SIGNED   = 1'b1;

    typedef struct packed {
        logic valid;
        logic neg_q;
        logic neg_r;
        logic div_zero;
    } t_ctl;

endpackage

// ----- design/idiv_pre.sv -----
module idiv_pre (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic                    i_operation,
    input  logic [idiv_pkg::W-1:0]  i_dividend,
    input  logic [idiv_pkg::W-1:0]  i_divisor,
    output idiv_pkg::t_ctl          o_ctl,
    output logic [idiv_pkg::W-1:0]  o_num,
    output logic [idiv_pkg::W-1:0]  o_den
);
    idiv_pkg::t_ctl r_ctl, n_ctl;
    logic [idiv_pkg::W-1:0] r_num, n_num, r_den, n_den;
    logic n_neg, d_neg;

    always_comb begin
        n_neg = (i_operation == idiv_pkg::OP_SIGNED) && i_dividend[idiv_pkg::W-1];
        d_neg = (i_operation == idiv_pkg::OP_SIGNED) && i_divisor[idiv_pkg::W-1];
        n_num = n_neg ? (~i_dividend + 1'b1) : i_dividend;
        n_den = d_neg ? (~i_divisor + 1'b1) : i_divisor;
        n_ctl.valid    = i_valid;
        n_ctl.neg_q    = n_neg ^ d_neg;
        n_ctl.neg_r    = n_neg;
        n_ctl.div_zero = (i_divisor == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_ctl.valid <= n_ctl.valid;
        end
        if (i_en) begin
            r_ctl.neg_q    <= n_ctl.neg_q;
            r_ctl.neg_r    <= n_ctl.neg_r;
            r_ctl.div_zero <= n_ctl.div_zero;
            r_num          <= n_num;
            r_den          <= n_den;
        end
    end

    assign o_ctl = r_ctl;
    assign o_num = r_num;
    assign o_den = r_den;
endmodule

// ----- design/idiv_stage.sv -----
module idiv_stage (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  idiv_pkg::t_ctl          i_ctl,
    input  logic [idiv_pkg::W-1:0]  i_rem,
    input  logic [idiv_pkg::W-1:0]  i_nq,
    input  logic [idiv_pkg::W-1:0]  i_den,
    output idiv_pkg::t_ctl          o_ctl,
    output logic [idiv_pkg::W-1:0]  o_rem,
    output logic [idiv_pkg::W-1:0]  o_nq,
    output logic [idiv_pkg::W-1:0]  o_den
);
    idiv_pkg::t_ctl r_ctl;
    logic [idiv_pkg::W-1:0] r_rem, n_rem, r_nq, n_nq, r_den;
    logic [idiv_pkg::W:0]   trial;
    logic                   fits;

    // The dividend shifts out of the top of nq while quotient bits enter at the bottom.
    always_comb begin
        trial = {i_rem, i_nq[idiv_pkg::W-1]} - {1'b0, i_den};
        fits  = !trial[idiv_pkg::W];
        n_rem = fits ? trial[idiv_pkg::W-1:0] : {i_rem[idiv_pkg::W-2:0], i_nq[idiv_pkg::W-1]};
        n_nq  = {i_nq[idiv_pkg::W-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_ctl.valid <= i_ctl.valid;
        end
        if (i_en) begin
            r_ctl.neg_q    <= i_ctl.neg_q;
            r_ctl.neg_r    <= i_ctl.neg_r;
            r_ctl.div_zero <= i_ctl.div_zero;
            r_rem          <= n_rem;
            r_nq           <= n_nq;
            r_den          <= i_den;
        end
    end

    assign o_ctl = r_ctl;
    assign o_rem = r_rem;
    assign o_nq  = r_nq;
    assign o_den = r_den;
endmodule

// ----- design/idiv_post.sv -----
module idiv_post (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  idiv_pkg::t_ctl          i_ctl,
    input  logic [idiv_pkg::W-1:0]  i_rem,
    input  logic [idiv_pkg::W-1:0]  i_quo,
    output logic                    o_valid,
    output logic [idiv_pkg::W-1:0]  o_quotient,
    output logic [idiv_pkg::W-1:0]  o_remainder
);
    logic                   r_valid;
    logic [idiv_pkg::W-1:0] r_quo, n_quo, r_rem, n_rem, rem_raw;

    // A zero divisor leaves the dividend in the remainder; the answer wants zero.
    always_comb begin
        rem_raw = i_ctl.div_zero ? '0 : i_rem;
        n_quo   = i_ctl.neg_q ? (~i_quo + 1'b1) : i_quo;
        n_rem   = i_ctl.neg_r ? (~rem_raw + 1'b1) : rem_raw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_ctl.valid;
        end
        if (i_en) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_valid     = r_valid;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;
endmodule

// ----- design/int64_divider_signed_unsigned_core.sv -----
// Fully pipelined divider: one beat may enter every cycle.
// Stages: one for operand magnitudes, 64 restoring steps of one
// quotient bit each, and one for sign and divide-by-zero correction.
// A stall on the output holds the whole pipeline; nothing is dropped.
// Reset is synchronous, active low, and clears only the valid bits.
module int64_divider_signed_unsigned_core (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic                    i_operation,
    input  logic [idiv_pkg::W-1:0]  i_dividend,
    input  logic [idiv_pkg::W-1:0]  i_divisor,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [idiv_pkg::W-1:0]  o_quotient,
    output logic [idiv_pkg::W-1:0]  o_remainder_out
);
    idiv_pkg::t_ctl         ctl [0:idiv_pkg::W];
    logic [idiv_pkg::W-1:0] rem [0:idiv_pkg::W];
    logic [idiv_pkg::W-1:0] nq  [0:idiv_pkg::W];
    logic [idiv_pkg::W-1:0] den [0:idiv_pkg::W];
    logic                   en;

    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;
    assign rem[0]  = '0;

    idiv_pre u_pre (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (i_valid),
        .i_operation (i_operation),
        .i_dividend  (i_dividend),
        .i_divisor   (i_divisor),
        .o_ctl       (ctl[0]),
        .o_num       (nq[0]),
        .o_den       (den[0])
    );

    for (genvar g = 0; g < idiv_pkg::W; g++) begin : g_step
        idiv_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (ctl[g]),
            .i_rem   (rem[g]),
            .i_nq    (nq[g]),
            .i_den   (den[g]),
            .o_ctl   (ctl[g+1]),
            .o_rem   (rem[g+1]),
            .o_nq    (nq[g+1]),
            .o_den   (den[g+1])
        );
    end

    idiv_post u_post (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_ctl       (ctl[idiv_pkg::W]),
        .i_rem       (rem[idiv_pkg::W]),
        .i_quo       (nq[idiv_pkg::W]),
        .o_valid     (o_valid),
        .o_quotient  (o_quotient),
        .o_remainder (o_remainder_out)
    );
endmodule
